// ===== design/rlrv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling volatility package
// Shared payload types, controller command and status types, and constants.
// ----------------------------------------------------------------------------
package rlrv_pkg;

  // Input item: one price sample and the new-series flag.
  typedef struct packed {
    logic signed [31:0] price;
    logic               new_series;
  } in_item_t;

  // Result item: annualised deviation and error status.
  typedef struct packed {
    logic [31:0] volatility;
    logic        status;
  } out_item_t;

  // Fixed-point constants.
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [31:0] SQRT252_Q24  = 32'd266330047;
  localparam logic [8:0]  WIN_LEN_RST  = 9'd20;

  // Iteration counts of the log, divide and root units, and the width of their step counter.
  localparam int unsigned LOG_STEPS  = 32;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned CNT_W      = 6;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_FAIL,
    OP_NORM,
    OP_LOG,
    OP_FIRST,
    OP_DIFF,
    OP_MULHI,
    OP_MULLO,
    OP_SQOLD,
    OP_SQNEW,
    OP_DIV_INIT,
    OP_DIV,
    OP_MEAN2,
    OP_SQRT,
    OP_VOL,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    logic   in_take;
    logic   cfg_take;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic failed;
    logic price_bad;
    logic have_prev;
    logic norm_done;
    logic log_last;
    logic div_last;
    logic sqrt_last;
    logic win_full;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== design/rolling_log_return_volatility_unit.sv =====
`timescale 1ns / 1ps
// From input transfer to the earliest result for a price that fills the window, the
// unit runs normalisation, 32 log steps, 64 divide steps and 32 root steps in turn.
// One price at a time: the next input is taken only once the current price is done,
// including any wait to hand its result to the output. Reset is asynchronous, active
// low: window length 20, empty window and sums, no series history.
// ----------------------------------------------------------------------------
// Rolling log-return volatility unit
// Top level joining the sequencing controller to the arithmetic datapath.
// ----------------------------------------------------------------------------
module rolling_log_return_volatility_unit #(
  parameter int unsigned WINDOW_MAX = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rlrv_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rlrv_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [8:0]          cfg_data_i
);

  rlrv_pkg::dp_cmd_t    cmd;
  rlrv_pkg::dp_status_t status;

  // Sequencer.
  rlrv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cfg_valid_i (cfg_valid_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage.
  rlrv_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .status_o    (status)
  );

`ifndef SYNTH
  // An error result never carries a volatility value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status) |-> (out_item_o.volatility == 32'd0))
    else $error("error result with non-zero volatility");

  // Eviction only happens with a full window.
  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == rlrv_pkg::OP_SQOLD) |-> status.win_full)
    else $error("eviction from a window that is not full");

  // A result is loaded only when the output register is free.
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == rlrv_pkg::OP_OUT) |-> !status.out_busy)
    else $error("result loaded over a pending transfer");
`endif

endmodule

// ===== design/rlrv_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling volatility controller
// Sequences one price at a time: log, window update, divide and root if full.
// ----------------------------------------------------------------------------
module rlrv_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                cfg_valid_i,
  input  rlrv_pkg::dp_status_t status_i,
  output logic                in_ready_o,
  output logic                cfg_ready_o,
  output rlrv_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_NORM, S_LOG, S_LOGEND, S_MULHI, S_MULLO, S_SQOLD,
    S_SQNEW, S_CHK, S_DIV, S_MEAN2, S_SQRT, S_VOL, S_OUT
  } state_e;

  state_e state_q, state_d;

  // Next state and the command for the current state.
  always_comb begin
    state_d       = state_q;
    cmd_o.in_take = 1'b0;
    cmd_o.cfg_take = 1'b0;
    cmd_o.op      = rlrv_pkg::OP_IDLE;
    case (state_q)
      S_IDLE: begin
        cmd_o.cfg_take = cfg_valid_i;
        cmd_o.in_take  = in_valid_i;
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (status_i.failed) begin
          state_d = S_IDLE;
        end else if (status_i.price_bad) begin
          cmd_o.op = rlrv_pkg::OP_FAIL;
          state_d  = S_OUT;
        end else begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        cmd_o.op = rlrv_pkg::OP_NORM;
        if (status_i.norm_done) state_d = S_LOG;
      end
      S_LOG: begin
        cmd_o.op = rlrv_pkg::OP_LOG;
        if (status_i.log_last) state_d = S_LOGEND;
      end
      S_LOGEND: begin
        if (status_i.have_prev) begin
          cmd_o.op = rlrv_pkg::OP_DIFF;
          state_d  = S_MULHI;
        end else begin
          cmd_o.op = rlrv_pkg::OP_FIRST;
          state_d  = S_IDLE;
        end
      end
      S_MULHI: begin
        cmd_o.op = rlrv_pkg::OP_MULHI;
        state_d  = S_MULLO;
      end
      S_MULLO: begin
        cmd_o.op = rlrv_pkg::OP_MULLO;
        state_d  = status_i.win_full ? S_SQOLD : S_SQNEW;
      end
      S_SQOLD: begin
        cmd_o.op = rlrv_pkg::OP_SQOLD;
        state_d  = S_SQNEW;
      end
      S_SQNEW: begin
        cmd_o.op = rlrv_pkg::OP_SQNEW;
        state_d  = S_CHK;
      end
      S_CHK: begin
        if (status_i.win_full) begin
          cmd_o.op = rlrv_pkg::OP_DIV_INIT;
          state_d  = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.op = rlrv_pkg::OP_DIV;
        if (status_i.div_last) state_d = S_MEAN2;
      end
      S_MEAN2: begin
        cmd_o.op = rlrv_pkg::OP_MEAN2;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = rlrv_pkg::OP_SQRT;
        if (status_i.sqrt_last) state_d = S_VOL;
      end
      S_VOL: begin
        cmd_o.op = rlrv_pkg::OP_VOL;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.op = rlrv_pkg::OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/rlrv_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling volatility datapath
// Log unit, return window ring, running sums, dividers, root and output stage.
// ----------------------------------------------------------------------------
module rlrv_datapath #(
  parameter int unsigned WINDOW_MAX = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rlrv_pkg::dp_cmd_t     cmd_i,
  input  rlrv_pkg::in_item_t    in_item_i,
  input  logic [8:0]            cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output rlrv_pkg::out_item_t   out_item_o,
  output rlrv_pkg::dp_status_t  status_o
);

  localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned LW = (CW > 9) ? CW : 9;
  localparam int unsigned SW = AW + 32;

  // Control state.
  logic [8:0]                   win_len_q;
  logic                         have_prev_q, failed_q, res_err_q, out_valid_q;
  logic [AW-1:0]                wslot_q;
  logic [CW-1:0]                fill_q;
  logic [rlrv_pkg::CNT_W-1:0]   cnt_q;

  // Payload state.
  logic signed [31:0]           price_q;
  logic [31:0]                  m_q, f_q;
  logic [4:0]                   e_q;
  logic [36:0]                  prev_log_q, mag_q;
  logic                         neg_q;
  logic [53:0]                  acc_q;
  logic signed [31:0]           r_q;
  logic [31:0]                  rd_q;
  logic signed [SW-1:0]         sum_q;
  logic [63:0]                  sq_q;
  logic [63:0]                  qa_q, qb_q;
  logic [CW-1:0]                ra_q, rb_q;
  logic [63:0]                  v_q;
  logic [33:0]                  srem_q;
  logic [31:0]                  root_q, vol_q;
  rlrv_pkg::out_item_t          out_q;
  logic [31:0]                  ring_mem [WINDOW_MAX];

  // Effective window length, clamped to one through the maximum.
  logic [LW-1:0] wl_ext, w_lim;
  logic [CW-1:0] w_eff;
  always_comb begin
    wl_ext = LW'(win_len_q);
    if (wl_ext == '0) w_lim = LW'(1);
    else if (wl_ext > LW'(WINDOW_MAX)) w_lim = LW'(WINDOW_MAX);
    else w_lim = wl_ext;
    w_eff = CW'(w_lim);
  end

  // Slot of the oldest return in the window.
  logic [CW:0]   ws_x, w_x, old_x;
  logic [AW-1:0] old_slot, wslot_inc;
  always_comb begin
    ws_x = (CW+1)'(wslot_q);
    w_x  = (CW+1)'(w_eff);
    if (ws_x >= w_x) old_x = ws_x - w_x;
    else old_x = ws_x + (CW+1)'(WINDOW_MAX) - w_x;
    old_slot  = AW'(old_x);
    wslot_inc = (wslot_q == AW'(WINDOW_MAX - 1)) ? '0 : wslot_q + AW'(1);
  end

  // Magnitudes of the new and the evicted return.
  logic [31:0] r_abs, old_abs;
  logic [SW-1:0] sum_abs;
  assign r_abs   = r_q[31] ? (~r_q + 32'd1) : r_q;
  assign old_abs = rd_q[31] ? (~rd_q + 32'd1) : rd_q;
  assign sum_abs = sum_q[SW-1] ? (~sum_q + SW'(1)) : sum_q;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    mul_a = m_q;
    mul_b = m_q;
    case (cmd_i.op)
      rlrv_pkg::OP_MULHI: begin
        mul_a = 32'(mag_q[36:16]);
        mul_b = rlrv_pkg::LN2_Q32;
      end
      rlrv_pkg::OP_MULLO: begin
        mul_a = 32'(mag_q[15:0]);
        mul_b = rlrv_pkg::LN2_Q32;
      end
      rlrv_pkg::OP_SQOLD: begin
        mul_a = old_abs;
        mul_b = old_abs;
      end
      rlrv_pkg::OP_SQNEW: begin
        mul_a = r_abs;
        mul_b = r_abs;
      end
      rlrv_pkg::OP_MEAN2: begin
        mul_a = qb_q[31:0];
        mul_b = qb_q[31:0];
      end
      rlrv_pkg::OP_VOL: begin
        mul_a = root_q;
        mul_b = rlrv_pkg::SQRT252_Q24;
      end
      default: begin
        mul_a = m_q;
        mul_b = m_q;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Log return rounding and saturation.
  logic [53:0] ret_sum;
  logic [33:0] ret_mag;
  logic [31:0] ret_val;
  always_comb begin
    ret_sum = acc_q + 54'(mul_p[63:16]) + 54'd524288;
    ret_mag = ret_sum[53:20];
    if (neg_q) begin
      ret_val = (ret_mag > 34'h080000000) ? 32'h80000000 : (~ret_mag[31:0] + 32'd1);
    end else begin
      ret_val = (ret_mag > 34'h07FFFFFFF) ? 32'h7FFFFFFF : ret_mag[31:0];
    end
  end

  // Log difference against the previous price.
  logic [36:0] log_now;
  assign log_now = {e_q, f_q};

  // Divider steps for both quotients.
  logic [CW:0] ra_sh, rb_sh;
  assign ra_sh = {ra_q, qa_q[63]};
  assign rb_sh = {rb_q, qb_q[63]};

  // Root step.
  logic [35:0] sr_sh, sr_trial;
  assign sr_sh    = {srem_q, v_q[63:62]};
  assign sr_trial = 36'({root_q, 2'b01});

  // Variance and scaled deviation.
  logic [63:0] mean2, var_v;
  logic [39:0] vol_t;
  assign mean2 = {8'd0, mul_p[63:8]};
  assign var_v = (qa_q > mean2) ? (qa_q - mean2) : 64'd0;
  assign vol_t = 40'((mul_p + 64'd8388608) >> 24);

  logic win_full;
  assign win_full = (fill_q >= w_eff);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= rlrv_pkg::WIN_LEN_RST;
      have_prev_q <= 1'b0;
      failed_q    <= 1'b0;
      res_err_q   <= 1'b0;
      out_valid_q <= 1'b0;
      wslot_q     <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.cfg_take) begin
        win_len_q <= cfg_data_i;
        wslot_q   <= '0;
        fill_q    <= '0;
      end
      if (cmd_i.in_take && in_item_i.new_series) begin
        have_prev_q <= 1'b0;
        failed_q    <= 1'b0;
        wslot_q     <= '0;
        fill_q      <= '0;
      end
      case (cmd_i.op)
        rlrv_pkg::OP_FAIL: begin
          failed_q  <= 1'b1;
          res_err_q <= 1'b1;
        end
        rlrv_pkg::OP_NORM:  cnt_q <= '0;
        rlrv_pkg::OP_LOG:   cnt_q <= cnt_q + 1'b1;
        rlrv_pkg::OP_FIRST: have_prev_q <= 1'b1;
        rlrv_pkg::OP_SQNEW: begin
          wslot_q <= wslot_inc;
          fill_q  <= win_full ? w_eff : fill_q + CW'(1);
        end
        rlrv_pkg::OP_DIV_INIT: cnt_q <= '0;
        rlrv_pkg::OP_DIV:   cnt_q <= cnt_q + 1'b1;
        rlrv_pkg::OP_MEAN2: cnt_q <= '0;
        rlrv_pkg::OP_SQRT:  cnt_q <= cnt_q + 1'b1;
        rlrv_pkg::OP_VOL:   res_err_q <= 1'b0;
        rlrv_pkg::OP_OUT:   out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Running sums of the returns and of their squares.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      sq_q  <= '0;
    end else if (cmd_i.cfg_take || (cmd_i.in_take && in_item_i.new_series)) begin
      sum_q <= '0;
      sq_q  <= '0;
    end else if (cmd_i.op == rlrv_pkg::OP_SQOLD) begin
      sum_q <= sum_q - SW'($signed(rd_q));
      sq_q  <= sq_q - {8'd0, mul_p[63:8]};
    end else if (cmd_i.op == rlrv_pkg::OP_SQNEW) begin
      sum_q <= sum_q + SW'(r_q);
      sq_q  <= sq_q + {8'd0, mul_p[63:8]};
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      price_q <= in_item_i.price;
      m_q     <= in_item_i.price;
      e_q     <= 5'd31;
      f_q     <= '0;
    end
    case (cmd_i.op)
      rlrv_pkg::OP_NORM: begin
        if (!m_q[31]) begin
          m_q <= {m_q[30:0], 1'b0};
          e_q <= e_q - 5'd1;
        end
      end
      rlrv_pkg::OP_LOG: begin
        if (mul_p[63]) begin
          m_q <= mul_p[63:32];
          f_q <= {f_q[30:0], 1'b1};
        end else begin
          m_q <= mul_p[62:31];
          f_q <= {f_q[30:0], 1'b0};
        end
      end
      rlrv_pkg::OP_FIRST: prev_log_q <= log_now;
      rlrv_pkg::OP_DIFF: begin
        neg_q      <= (log_now < prev_log_q);
        mag_q      <= (log_now < prev_log_q) ? (prev_log_q - log_now)
                                             : (log_now - prev_log_q);
        prev_log_q <= log_now;
        rd_q       <= ring_mem[old_slot];
      end
      rlrv_pkg::OP_MULHI: acc_q <= 54'(mul_p);
      rlrv_pkg::OP_MULLO: r_q <= ret_val;
      rlrv_pkg::OP_DIV_INIT: begin
        qa_q <= sq_q;
        qb_q <= 64'(sum_abs);
        ra_q <= '0;
        rb_q <= '0;
      end
      rlrv_pkg::OP_DIV: begin
        if (ra_sh >= (CW+1)'(w_eff)) begin
          ra_q <= CW'(ra_sh - (CW+1)'(w_eff));
          qa_q <= {qa_q[62:0], 1'b1};
        end else begin
          ra_q <= CW'(ra_sh);
          qa_q <= {qa_q[62:0], 1'b0};
        end
        if (rb_sh >= (CW+1)'(w_eff)) begin
          rb_q <= CW'(rb_sh - (CW+1)'(w_eff));
          qb_q <= {qb_q[62:0], 1'b1};
        end else begin
          rb_q <= CW'(rb_sh);
          qb_q <= {qb_q[62:0], 1'b0};
        end
      end
      rlrv_pkg::OP_MEAN2: begin
        v_q    <= var_v;
        srem_q <= '0;
        root_q <= '0;
      end
      rlrv_pkg::OP_SQRT: begin
        v_q <= {v_q[61:0], 2'b00};
        if (sr_sh >= sr_trial) begin
          srem_q <= 34'(sr_sh - sr_trial);
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          srem_q <= 34'(sr_sh);
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      rlrv_pkg::OP_VOL: vol_q <= (vol_t > 40'hFFFFFFFF) ? 32'hFFFFFFFF : vol_t[31:0];
      rlrv_pkg::OP_OUT: begin
        out_q.volatility <= res_err_q ? 32'd0 : vol_q;
        out_q.status     <= res_err_q;
      end
      default: ;
    endcase
  end

  // Return window ring.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == rlrv_pkg::OP_SQNEW) ring_mem[wslot_q] <= r_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Status towards the controller.
  always_comb begin
    status_o.failed    = failed_q;
    status_o.price_bad = price_q[31] || (price_q == 32'sd0);
    status_o.have_prev = have_prev_q;
    status_o.norm_done = m_q[31];
    status_o.log_last  = (cnt_q == rlrv_pkg::CNT_W'(rlrv_pkg::LOG_STEPS - 1));
    status_o.div_last  = (cnt_q == rlrv_pkg::CNT_W'(rlrv_pkg::DIV_STEPS - 1));
    status_o.sqrt_last = (cnt_q == rlrv_pkg::CNT_W'(rlrv_pkg::SQRT_STEPS - 1));
    status_o.win_full  = win_full;
    status_o.out_busy  = out_valid_q && !out_ready_i;
  end

endmodule
